// File: sv/mar_pkg.sv
// Shared types, constants and helper functions of the matrix axis rotation unit.
// No dependencies; every other file of the unit refers to it by scoped names.
`default_nettype none

package mar_pkg;

   // Sine table geometry: quarter wave, 2^SINE_TABLE_BITS + 1 entries of Q1.14
   localparam int SINE_TABLE_BITS = 10;
   localparam int TABLE_N         = 1 << SINE_TABLE_BITS;
   localparam int ROM_AW          = SINE_TABLE_BITS + 1;
   localparam int ROM_W           = 15;
   localparam int TRIG_W          = 16;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // Datapath widths
   localparam int ELEM_W = 32;
   localparam int PROD_W = ELEM_W + TRIG_W;
   localparam int SUM_W  = PROD_W + 1;
   localparam logic signed [ELEM_W-1:0] ONE_Q16 = 32'sh0001_0000;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // Axis codes
   localparam logic [1:0] AXIS_X    = 2'd0;
   localparam logic [1:0] AXIS_Y    = 2'd1;
   localparam logic [1:0] AXIS_Z    = 2'd2;
   localparam logic [1:0] AXIS_NONE = 2'd3;

   typedef enum logic [1:0] {
      CMD_NEW   = 2'd0,
      CMD_APPLY = 2'd1,
      CMD_WRITE = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_APPLY,
      BACK_READ
   } back_state_type;

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef elem_type [3:0] row_type;
   typedef row_type [3:0] matrix_type;

   typedef logic [ROM_W-1:0] sine_rom_type [0:TABLE_N];

   // One queued command word, trig values already looked up and signed
   typedef struct packed {
      cmd_type                   cmd;
      logic [1:0]                axis;
      logic [3:0]                index;
      logic signed [ELEM_W-1:0]  value;
      logic signed [TRIG_W-1:0]  sin;
      logic signed [TRIG_W-1:0]  cos;
   } word_type;

   typedef struct packed {
      logic [3:0]         index;
      logic [ELEM_W-1:0]  value;
      logic               last;
   } result_type;

   function automatic matrix_type identity_matrix();
      matrix_type m;
      m = '0;
      for (int d = 0; d < 4; d++) begin
         m[d][d] = ONE_Q16;
      end
      return m;
   endfunction

   // Column that takes a*c + b*s for the axis
   function automatic logic [1:0] col_a(input logic [1:0] axis);
      logic [1:0] c;
      case (axis)
         AXIS_X:  c = 2'd1;
         AXIS_Y:  c = 2'd2;
         AXIS_Z:  c = 2'd0;
         default: c = 2'd0;
      endcase
      return c;
   endfunction

   // Column that takes b*c - a*s for the axis
   function automatic logic [1:0] col_b(input logic [1:0] axis);
      logic [1:0] c;
      case (axis)
         AXIS_X:  c = 2'd2;
         AXIS_Y:  c = 2'd0;
         AXIS_Z:  c = 2'd1;
         default: c = 2'd1;
      endcase
      return c;
   endfunction

   // Divide by 2^14 rounding half up, then clamp to the signed 32-bit range
   function automatic elem_type round_sat(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] r;
      elem_type                o;
      r = v + $signed(SUM_W'(8192));
      r = r >>> 14;
      if (r[SUM_W-1:ELEM_W-1] == '0 || r[SUM_W-1:ELEM_W-1] == '1) begin
         o = r[ELEM_W-1:0];
      end else if (r[SUM_W-1]) begin
         o = {1'b1, {(ELEM_W-1){1'b0}}};
      end else begin
         o = {1'b0, {(ELEM_W-1){1'b1}}};
      end
      return o;
   endfunction

   // Quarter-wave sine table, Taylor series in Q30, evaluated at elaboration
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type        rom;
      logic [63:0]         t;
      logic [63:0]         t2;
      logic [63:0]         term;
      logic [63:0]         prod;
      logic [63:0]         v;
      logic signed [63:0]  sum;
      for (int k = 0; k <= TABLE_N; k++) begin
         t    = (64'(k) * HALF_PI_Q30) >> SINE_TABLE_BITS;
         t2   = (t * t) >> 30;
         term = t;
         sum  = $signed(t);
         for (int n = 1; n <= 7; n++) begin
            prod = (term * t2) >> 30;
            case (n)
               1:       term = prod / 64'd6;
               2:       term = prod / 64'd20;
               3:       term = prod / 64'd42;
               4:       term = prod / 64'd72;
               5:       term = prod / 64'd110;
               6:       term = prod / 64'd156;
               default: term = prod / 64'd210;
            endcase
            if (n[0]) begin
               sum = sum - $signed(term);
            end else begin
               sum = sum + $signed(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         v = ($unsigned(sum) + 64'd32768) >> 16;
         if (v > 64'd16384) begin
            v = 64'd16384;
         end
         rom[k] = v[ROM_W-1:0];
      end
      return rom;
   endfunction

endpackage

`default_nettype wire

// File: sv/mar_queue.sv
// Short command queue between the front and back parts of the rotation unit.
// Depends on mar_pkg for the queued word type and depth.
`default_nettype none

module mar_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire mar_pkg::word_type push_word,
   output logic                   full,
   input  wire logic              pop,
   output mar_pkg::word_type      pop_word,
   output logic                   empty
);

   mar_pkg::word_type                  mem_ff [mar_pkg::QUEUE_DEPTH];
   logic [mar_pkg::QUEUE_AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [mar_pkg::QUEUE_AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [mar_pkg::QUEUE_AW:0]         count_ff, count_in;
   logic                               do_push, do_pop;

   assign full     = (count_ff == (mar_pkg::QUEUE_AW+1)'(mar_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_word = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

`default_nettype wire

// File: sv/mar_front.sv
// Front part of the rotation unit: accepts request words, drops no-op rotations,
// looks up sine and cosine in the quarter-wave ROM. Depends on mar_pkg.
`default_nettype none

module mar_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_push,
   output logic                           req_full,
   input  wire logic [1:0]                req_cmd,
   input  wire logic [1:0]                req_axis,
   input  wire logic signed [15:0]        req_angle,
   input  wire logic [3:0]                req_element_index,
   input  wire logic signed [31:0]        req_element_value,
   output logic                           q_push,
   output mar_pkg::word_type              q_word,
   input  wire logic                      q_full
);

   localparam mar_pkg::sine_rom_type SineRom = mar_pkg::build_sine_rom();

   logic                                  accept;
   logic                                  keep;
   mar_pkg::cmd_type                      cmd;
   logic [15:0]                           phase;
   logic [1:0]                            quad;
   logic [mar_pkg::ROM_AW-1:0]            addr_lo, addr_hi, addr_s, addr_c;

   logic                                  stg_valid_ff, stg_valid_in;
   mar_pkg::cmd_type                      stg_cmd_ff;
   logic [1:0]                            stg_axis_ff;
   logic [3:0]                            stg_index_ff;
   logic signed [31:0]                    stg_value_ff;
   logic [mar_pkg::ROM_W-1:0]             rom_s_ff, rom_c_ff;
   logic                                  sin_neg_ff, cos_neg_ff;
   logic signed [mar_pkg::TRIG_W-1:0]     sin_mag, cos_mag;

   assign cmd      = mar_pkg::cmd_type'(req_cmd);
   assign req_full = stg_valid_ff && q_full;
   assign accept   = req_push && !req_full;
   assign q_push   = stg_valid_ff && !q_full;

   // Rotations about axis three change nothing: drop them here
   assign keep = !((cmd == mar_pkg::CMD_NEW || cmd == mar_pkg::CMD_APPLY) &&
                   req_axis == mar_pkg::AXIS_NONE);

   // Odd quadrants read the table backwards; cosine is a quarter turn ahead
   assign phase   = req_angle;
   assign quad    = phase[15:14];
   assign addr_lo = {1'b0, phase[13:14-mar_pkg::SINE_TABLE_BITS]};
   assign addr_hi = mar_pkg::ROM_AW'(mar_pkg::TABLE_N) - addr_lo;
   assign addr_s  = quad[0] ? addr_hi : addr_lo;
   assign addr_c  = quad[0] ? addr_lo : addr_hi;

   always_comb begin
      stg_valid_in = stg_valid_ff;
      if (accept) begin
         stg_valid_in = keep;
      end else if (q_push) begin
         stg_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rom_s_ff     <= SineRom[addr_s];
         rom_c_ff     <= SineRom[addr_c];
         sin_neg_ff   <= quad[1];
         cos_neg_ff   <= quad[1] ^ quad[0];
         stg_cmd_ff   <= cmd;
         stg_axis_ff  <= req_axis;
         stg_index_ff <= req_element_index;
         stg_value_ff <= req_element_value;
      end
   end

   assign sin_mag = {1'b0, rom_s_ff};
   assign cos_mag = {1'b0, rom_c_ff};

   always_comb begin
      q_word.cmd   = stg_cmd_ff;
      q_word.axis  = stg_axis_ff;
      q_word.index = stg_index_ff;
      q_word.value = stg_value_ff;
      q_word.sin   = sin_neg_ff ? -sin_mag : sin_mag;
      q_word.cos   = cos_neg_ff ? -cos_mag : cos_mag;
   end

endmodule

`default_nettype wire

// File: sv/mar_back.sv
// Back part of the rotation unit: holds the current matrix, runs row rotations,
// loads and overwrites elements, streams reads into the result buffer. Uses mar_pkg.
`default_nettype none

module mar_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire mar_pkg::word_type   head_word,
   input  wire logic                head_empty,
   output logic                     head_pop,
   output logic                     rsp_empty,
   input  wire logic                rsp_pop,
   output logic [3:0]               rsp_out_index,
   output logic signed [31:0]       rsp_out_value,
   output logic                     rsp_last
);

   mar_pkg::back_state_type               state_ff, state_in;
   logic [3:0]                            cnt_ff, cnt_in;
   logic [1:0]                            cur_axis_ff;
   logic signed [mar_pkg::TRIG_W-1:0]     cur_sin_ff, cur_cos_ff;
   mar_pkg::matrix_type                   mat_ff, mat_in;

   logic                                  finish_apply, finish_read, can_take, take;
   logic                                  out_room, out_push, out_pop;
   logic                                  issue_row, exec_new, exec_write;

   logic [1:0]                            row_sel, ca, cb;
   mar_pkg::row_type                      rd_row;
   mar_pkg::elem_type                     a_val, b_val;

   logic                                  wb_valid_ff;
   logic [1:0]                            wb_row_ff, wb_ca_ff, wb_cb_ff;
   logic signed [mar_pkg::PROD_W-1:0]     pac_ff, pbs_ff, pbc_ff, pas_ff;
   logic signed [mar_pkg::SUM_W-1:0]      sum_a, sum_b;

   mar_pkg::result_type                   out_mem_ff [2];
   mar_pkg::result_type                   push_word;
   logic                                  out_wr_ff, out_rd_ff;
   logic [1:0]                            out_cnt_ff, out_cnt_in;

   function automatic mar_pkg::matrix_type rotation_matrix(
      input logic [1:0]                         axis,
      input logic signed [mar_pkg::TRIG_W-1:0]  s,
      input logic signed [mar_pkg::TRIG_W-1:0]  c
   );
      mar_pkg::matrix_type  m;
      mar_pkg::elem_type    sq, cq;
      sq = {{14{s[15]}}, s, 2'b00};
      cq = {{14{c[15]}}, c, 2'b00};
      m  = '0;
      m[3][3] = mar_pkg::ONE_Q16;
      case (axis)
         mar_pkg::AXIS_X: begin
            m[0][0] = mar_pkg::ONE_Q16;
            m[1][1] = cq;
            m[2][2] = cq;
            m[2][1] = sq;
            m[1][2] = -sq;
         end
         mar_pkg::AXIS_Y: begin
            m[1][1] = mar_pkg::ONE_Q16;
            m[0][0] = cq;
            m[2][2] = cq;
            m[0][2] = sq;
            m[2][0] = -sq;
         end
         default: begin
            m[2][2] = mar_pkg::ONE_Q16;
            m[0][0] = cq;
            m[1][1] = cq;
            m[1][0] = sq;
            m[0][1] = -sq;
         end
      endcase
      return m;
   endfunction

   // Sequencer conditions
   always_comb begin
      out_room     = (out_cnt_ff != 2'd2);
      finish_apply = (state_ff == mar_pkg::BACK_APPLY) && (cnt_ff[1:0] == 2'd3);
      finish_read  = (state_ff == mar_pkg::BACK_READ) && (cnt_ff == 4'd15) && out_room;
      can_take     = (state_ff == mar_pkg::BACK_IDLE) || finish_apply || finish_read;
      // hold loads and overwrites until the last row of an apply is written back
      take = can_take && !head_empty &&
             !(finish_apply && (head_word.cmd == mar_pkg::CMD_NEW ||
                                head_word.cmd == mar_pkg::CMD_WRITE));
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      if (take) begin
         cnt_in = '0;
         case (head_word.cmd)
            mar_pkg::CMD_APPLY: state_in = mar_pkg::BACK_APPLY;
            mar_pkg::CMD_READ:  state_in = mar_pkg::BACK_READ;
            default:            state_in = mar_pkg::BACK_IDLE;
         endcase
      end else begin
         if (finish_apply || finish_read) begin
            state_in = mar_pkg::BACK_IDLE;
         end
         if ((state_ff == mar_pkg::BACK_APPLY) ||
             (state_ff == mar_pkg::BACK_READ && out_room)) begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   // Outputs of the sequencer
   always_comb begin
      head_pop   = take;
      exec_new   = take && (head_word.cmd == mar_pkg::CMD_NEW);
      exec_write = take && (head_word.cmd == mar_pkg::CMD_WRITE);
      issue_row  = (state_ff == mar_pkg::BACK_APPLY);
      out_push   = (state_ff == mar_pkg::BACK_READ) && out_room;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mar_pkg::BACK_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cur_axis_ff <= head_word.axis;
         cur_sin_ff  <= head_word.sin;
         cur_cos_ff  <= head_word.cos;
      end
   end

   // One row read per cycle: apply walks rows, read walks elements while the buffer has room
   assign row_sel = (state_ff == mar_pkg::BACK_READ) ? cnt_ff[3:2] : cnt_ff[1:0];
   assign rd_row  = mat_ff[row_sel];
   assign ca      = mar_pkg::col_a(cur_axis_ff);
   assign cb      = mar_pkg::col_b(cur_axis_ff);
   assign a_val   = rd_row[ca];
   assign b_val   = rd_row[cb];

   always_ff @(posedge clock) begin
      if (reset) begin
         wb_valid_ff <= 1'b0;
      end else begin
         wb_valid_ff <= issue_row;
      end
   end

   always_ff @(posedge clock) begin
      if (issue_row) begin
         wb_row_ff <= cnt_ff[1:0];
         wb_ca_ff  <= ca;
         wb_cb_ff  <= cb;
         pac_ff    <= mar_pkg::PROD_W'(a_val) * mar_pkg::PROD_W'(cur_cos_ff);
         pbs_ff    <= mar_pkg::PROD_W'(b_val) * mar_pkg::PROD_W'(cur_sin_ff);
         pbc_ff    <= mar_pkg::PROD_W'(b_val) * mar_pkg::PROD_W'(cur_cos_ff);
         pas_ff    <= mar_pkg::PROD_W'(a_val) * mar_pkg::PROD_W'(cur_sin_ff);
      end
   end

   assign sum_a = mar_pkg::SUM_W'(pac_ff) + mar_pkg::SUM_W'(pbs_ff);
   assign sum_b = mar_pkg::SUM_W'(pbc_ff) - mar_pkg::SUM_W'(pas_ff);

   // Matrix update: row write-back first, a later load or overwrite wins
   always_comb begin
      mat_in = mat_ff;
      if (wb_valid_ff) begin
         mat_in[wb_row_ff][wb_ca_ff] = mar_pkg::round_sat(sum_a);
         mat_in[wb_row_ff][wb_cb_ff] = mar_pkg::round_sat(sum_b);
      end
      if (exec_new) begin
         mat_in = rotation_matrix(head_word.axis, head_word.sin, head_word.cos);
      end
      if (exec_write) begin
         mat_in[head_word.index[3:2]][head_word.index[1:0]] = head_word.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mat_ff <= mar_pkg::identity_matrix();
      end else begin
         mat_ff <= mat_in;
      end
   end

   // Two-entry result buffer
   always_comb begin
      push_word.index = cnt_ff;
      push_word.value = rd_row[cnt_ff[1:0]];
      push_word.last  = (cnt_ff == 4'd15);
   end

   assign out_pop   = rsp_pop && (out_cnt_ff != 2'd0);
   assign rsp_empty = (out_cnt_ff == 2'd0);

   always_comb begin
      out_cnt_in = out_cnt_ff;
      if (out_push && !out_pop) begin
         out_cnt_in = out_cnt_ff + 1'b1;
      end else if (out_pop && !out_push) begin
         out_cnt_in = out_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ff  <= 1'b0;
         out_rd_ff  <= 1'b0;
         out_cnt_ff <= '0;
      end else begin
         out_wr_ff  <= out_wr_ff ^ out_push;
         out_rd_ff  <= out_rd_ff ^ out_pop;
         out_cnt_ff <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         out_mem_ff[out_wr_ff] <= push_word;
      end
   end

   assign rsp_out_index = out_mem_ff[out_rd_ff].index;
   assign rsp_out_value = out_mem_ff[out_rd_ff].value;
   assign rsp_last      = out_mem_ff[out_rd_ff].last;

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> !head_empty)
      else $error("queue popped while empty");

   a_wb_after_issue: assert property (@(posedge clock) disable iff (reset)
      wb_valid_ff |-> $past(state_ff == mar_pkg::BACK_APPLY))
      else $error("row write-back without a row issue");

   a_apply_overlap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mar_pkg::BACK_APPLY && head_pop) |->
         (cnt_ff[1:0] == 2'd3 &&
          (head_word.cmd == mar_pkg::CMD_APPLY || head_word.cmd == mar_pkg::CMD_READ)))
      else $error("command taken over a pending row write-back");

   a_read_ends: assert property (@(posedge clock) disable iff (reset)
      (out_push && push_word.last) |=>
         (state_ff != mar_pkg::BACK_READ || $past(head_pop)))
      else $error("read kept streaming past its last element");

   a_buffer_bound: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff != 2'd3)
      else $error("result buffer overflow");

endmodule

`default_nettype wire

// File: sv/matrix_axis_rotation_unit.sv
// Top level of the 4x4 matrix axis rotation unit: front, command queue, back.
// Depends on mar_pkg, mar_front, mar_queue and mar_back.
`default_nettype none

// The unit keeps a 4x4 Q16.16 matrix, the identity after reset. Request words
// enter through a queue-style port (push/full) and read results leave through
// one (empty/pop). cmd selects: new rotation (overwrite with a pure rotation
// about axis), apply rotation (rotate the two axis columns of every row),
// write element (load element_value at element_index = row*4+column) and read
// (stream all sixteen elements, index order, last set on the sixteenth).
// angle is a binary angle, 65536 units per turn; sine and cosine come from a
// built-in quarter-wave Q1.14 table. Rotated elements are rounded half up and
// saturated to 32 bits. Rotations about axis three are dropped.
// Rate: the front takes one word per cycle unless its stage is held by a full
// queue, and registers the table lookup; a four-entry queue then decouples it
// from the back. In the back an apply walks one matrix row per cycle through
// four 32x16 multipliers with a registered write-back behind them; a read
// streams one element per cycle through the single row read port while the
// two-entry result buffer has room. New and write update the matrix as they
// are taken from the queue. A new or write that directly follows an apply
// waits for the last row to be written back.
module matrix_axis_rotation_unit (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_push,
   output logic                     req_full,
   input  wire logic [1:0]          req_cmd,
   input  wire logic [1:0]          req_axis,
   input  wire logic signed [15:0]  req_angle,
   input  wire logic [3:0]          req_element_index,
   input  wire logic signed [31:0]  req_element_value,
   output logic                     rsp_empty,
   input  wire logic                rsp_pop,
   output logic [3:0]               rsp_out_index,
   output logic signed [31:0]       rsp_out_value,
   output logic                     rsp_last
);

   // front to queue
   logic                q_push;
   logic                q_full;
   mar_pkg::word_type   q_push_word;

   // queue to back
   logic                q_pop;
   logic                q_empty;
   mar_pkg::word_type   q_head_word;

   // Accept, classify, look up sine and cosine
   mar_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_cmd           (req_cmd),
      .req_axis          (req_axis),
      .req_angle         (req_angle),
      .req_element_index (req_element_index),
      .req_element_value (req_element_value),
      .q_push            (q_push),
      .q_word            (q_push_word),
      .q_full            (q_full)
   );

   // Hold commands while the back is busy with a long apply or read
   mar_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_word (q_push_word),
      .full      (q_full),
      .pop       (q_pop),
      .pop_word  (q_head_word),
      .empty     (q_empty)
   );

   // Execute against the matrix and drive the result port
   mar_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_word     (q_head_word),
      .head_empty    (q_empty),
      .head_pop      (q_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_out_index (rsp_out_index),
      .rsp_out_value (rsp_out_value),
      .rsp_last      (rsp_last)
   );

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench of the matrix axis rotation unit: directed table, then random words.
// Depends on mar_pkg (command enum, axis codes, table size) and matrix_axis_rotation_unit.
module testbench;
   import mar_pkg::*;

   typedef longint unsigned u64;

   localparam int TAB_BITS     = SINE_TABLE_BITS;
   localparam int TAB_N        = 1 << TAB_BITS;
   localparam u64 HALF_PI_Q30  = 64'd1686629713;
   localparam int RUN_LIMIT    = 800000;
   localparam int RANDOM_WORDS = 200;
   localparam int HOLD_CYCLES  = 500;
   localparam int HOLD_AFTER   = 240;
   localparam int DRAIN_CYCLES = 24;

   // Which typed-in matrix a directed read expects; PIN_NONE defers to the predictor
   typedef enum logic [1:0] {
      PIN_IDENTITY,
      PIN_CORNERS,
      PIN_QUARTER_Z,
      PIN_NONE
   } pinned_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [1:0]  axis;
      logic [15:0] angle;
      logic [3:0]  index;
      logic [31:0] value;
      pinned_type  pin;
   } request_row;

   typedef struct packed {
      logic [3:0]  index;
      logic [31:0] value;
      logic        last;
   } matrix_element;

   localparam logic [0:15][31:0] PINNED_MATRIX [0:2] = '{
      {32'h0001_0000, 32'h0, 32'h0, 32'h0,
       32'h0, 32'h0001_0000, 32'h0, 32'h0,
       32'h0, 32'h0, 32'h0001_0000, 32'h0,
       32'h0, 32'h0, 32'h0, 32'h0001_0000},
      {32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0,
       32'h0, 32'h0001_0000, 32'h0, 32'h0,
       32'h0, 32'h0, 32'h0001_0000, 32'h0,
       32'h0, 32'h0, 32'h0, 32'h8000_0000},
      {32'h0, 32'hFFFF_0000, 32'h0, 32'h0,
       32'h0001_0000, 32'h0, 32'h0, 32'h0,
       32'h0, 32'h0, 32'h0001_0000, 32'h0,
       32'h0, 32'h0, 32'h0, 32'h0001_0000}
   };

   localparam int DIRECTED_ROWS = 25;
   localparam request_row DIRECTED [0:DIRECTED_ROWS-1] = '{
      '{CMD_READ,  AXIS_X,    16'h0000, 4'd0,  32'h0,         PIN_IDENTITY},
      '{CMD_WRITE, AXIS_X,    16'h0000, 4'd0,  32'h7FFF_FFFF, PIN_NONE},
      '{CMD_WRITE, AXIS_X,    16'h0000, 4'd15, 32'h8000_0000, PIN_NONE},
      '{CMD_READ,  AXIS_X,    16'h0000, 4'd0,  32'h0,         PIN_CORNERS},
      // zero angle: cosine is exactly one, nothing moves
      '{CMD_APPLY, AXIS_X,    16'h0000, 4'd0,  32'h0,         PIN_NONE},
      '{CMD_APPLY, AXIS_Z,    16'h0000, 4'd0,  32'h0,         PIN_NONE},
      // axis three: dropped for both rotation kinds
      '{CMD_APPLY, AXIS_NONE, 16'h1234, 4'd0,  32'h0,         PIN_NONE},
      '{CMD_NEW,   AXIS_NONE, 16'h4000, 4'd0,  32'h0,         PIN_NONE},
      '{CMD_READ,  AXIS_X,    16'h0000, 4'd0,  32'h0,         PIN_CORNERS},
      // load full-scale values and rotate by 45 degrees to hit both clamps
      '{CMD_WRITE, AXIS_X,    16'h0000, 4'd1,  32'h7FFF_FFFF, PIN_NONE},
      '{CMD_WRITE, AXIS_X,    16'h0000, 4'd12, 32'h8000_0000, PIN_NONE},
      '{CMD_WRITE, AXIS_X,    16'h0000, 4'd13, 32'h8000_0000, PIN_NONE},
      '{CMD_APPLY, AXIS_Z,    16'h2000, 4'd0,  32'h0,         PIN_NONE},
      '{CMD_READ,  AXIS_X,    16'h0000, 4'd0,  32'h0,         PIN_NONE},
      '{CMD_NEW,   AXIS_Z,    16'h4000, 4'd0,  32'h0,         PIN_NONE},
      '{CMD_READ,  AXIS_X,    16'h0000, 4'd0,  32'h0,         PIN_QUARTER_Z},
      '{CMD_NEW,   AXIS_X,    16'h0000, 4'd0,  32'h0,         PIN_NONE},
      '{CMD_READ,  AXIS_X,    16'h0000, 4'd0,  32'h0,         PIN_IDENTITY},
      '{CMD_NEW,   AXIS_Y,    16'h8000, 4'd0,  32'h0,         PIN_NONE},
      '{CMD_APPLY, AXIS_Y,    16'h7FFF, 4'd0,  32'h0,         PIN_NONE},
      '{CMD_APPLY, AXIS_X,    16'hFFFF, 4'd0,  32'h0,         PIN_NONE},
      '{CMD_READ,  AXIS_X,    16'h0000, 4'd0,  32'h0,         PIN_NONE},
      '{CMD_NEW,   AXIS_X,    16'h3039, 4'd0,  32'h0,         PIN_NONE},
      '{CMD_APPLY, AXIS_Y,    16'hC000, 4'd0,  32'h0,         PIN_NONE},
      '{CMD_READ,  AXIS_X,    16'h0000, 4'd0,  32'h0,         PIN_NONE}
   };

   logic               clock;
   logic               reset;
   logic               req_push;
   logic               req_full;
   logic [1:0]         req_cmd;
   logic [1:0]         req_axis;
   logic signed [15:0] req_angle;
   logic [3:0]         req_element_index;
   logic signed [31:0] req_element_value;
   logic               rsp_empty;
   logic               rsp_pop;
   logic [3:0]         rsp_out_index;
   logic signed [31:0] rsp_out_value;
   logic               rsp_last;

   logic signed [31:0] model_mat [16];
   int                 sine_tab [0:TAB_N];
   matrix_element      expected_elements [$];
   int                 mismatches;
   int                 cycle_count;
   int                 tx_calm;
   int                 rx_calm;

   matrix_axis_rotation_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_cmd           (req_cmd),
      .req_axis          (req_axis),
      .req_angle         (req_angle),
      .req_element_index (req_element_index),
      .req_element_value (req_element_value),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_out_index     (rsp_out_index),
      .rsp_out_value     (rsp_out_value),
      .rsp_last          (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Quarter-wave Q1.14 sine table from an eight-term Taylor series in Q30
   function automatic void fill_sine_tab();
      u64     t;
      u64     t2;
      u64     term;
      u64     v;
      longint sum;
      for (int k = 0; k <= TAB_N; k++) begin
         t    = (u64'(k) * HALF_PI_Q30) >> TAB_BITS;
         t2   = (t * t) >> 30;
         term = t;
         sum  = longint'(t);
         for (int n = 1; n <= 7; n++) begin
            term = ((term * t2) >> 30) / u64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         v = (u64'(sum) + 64'd32768) >> 16;
         sine_tab[k] = (v > 64'd16384) ? 16384 : int'(v);
      end
   endfunction

   function automatic int sine_of(input logic [15:0] phase);
      int i;
      int v;
      i = int'(phase[13:0]) >> (14 - TAB_BITS);
      v = phase[14] ? sine_tab[TAB_N - i] : sine_tab[i];
      return phase[15] ? -v : v;
   endfunction

   // Divide by 2^14 rounding half up, then clamp to 32 bits
   function automatic logic signed [31:0] round_clamp(input longint x);
      longint r;
      r = (x + 64'sd8192) >>> 14;
      if (r > 64'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end
      if (r < -64'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return r[31:0];
   endfunction

   function automatic void turn_columns(input int ca, input int cb, input int s, input int c);
      longint a;
      longint b;
      for (int r = 0; r < 4; r++) begin
         a = longint'(model_mat[r * 4 + ca]);
         b = longint'(model_mat[r * 4 + cb]);
         model_mat[r * 4 + ca] = round_clamp(a * c + b * s);
         model_mat[r * 4 + cb] = round_clamp(b * c - a * s);
      end
   endfunction

   function automatic void reset_matrix_model();
      for (int i = 0; i < 16; i++) begin
         model_mat[i] = (i % 5 == 0) ? ONE_Q16 : 32'sh0;
      end
   endfunction

   // Update the matrix copy for one accepted word; queue the elements a read returns
   function automatic void advance_matrix_model(input request_row w);
      int            s;
      int            c;
      matrix_element e;
      case (w.cmd)
         CMD_WRITE: begin
            model_mat[w.index] = w.value;
         end
         CMD_READ: begin
            for (int i = 0; i < 16; i++) begin
               e.index = 4'(i);
               e.value = (w.pin == PIN_NONE) ? model_mat[i] : PINNED_MATRIX[w.pin][i];
               e.last  = (i == 15);
               expected_elements.push_back(e);
            end
         end
         default: begin
            if (w.axis != AXIS_NONE) begin
               s = sine_of(w.angle);
               c = sine_of(w.angle + 16'h4000);
               if (w.cmd == CMD_APPLY) begin
                  case (w.axis)
                     AXIS_X:  turn_columns(1, 2, s, c);
                     AXIS_Y:  turn_columns(2, 0, s, c);
                     default: turn_columns(0, 1, s, c);
                  endcase
               end else begin
                  for (int i = 0; i < 15; i++) begin
                     model_mat[i] = 32'sh0;
                  end
                  model_mat[15] = ONE_Q16;
                  case (w.axis)
                     AXIS_X: begin
                        model_mat[0]  = ONE_Q16;
                        model_mat[5]  = c * 4;
                        model_mat[10] = c * 4;
                        model_mat[9]  = s * 4;
                        model_mat[6]  = -s * 4;
                     end
                     AXIS_Y: begin
                        model_mat[5]  = ONE_Q16;
                        model_mat[0]  = c * 4;
                        model_mat[10] = c * 4;
                        model_mat[2]  = s * 4;
                        model_mat[8]  = -s * 4;
                     end
                     default: begin
                        model_mat[10] = ONE_Q16;
                        model_mat[0]  = c * 4;
                        model_mat[5]  = c * 4;
                        model_mat[4]  = s * 4;
                        model_mat[1]  = -s * 4;
                     end
                  endcase
               end
            end
         end
      endcase
   endfunction

   // Idle length: mostly none or short, a few long, with stretches of no idling
   function automatic int next_gap(inout int calm);
      int roll;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) begin
         calm = $urandom_range(8, 40);
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
         return 0;
      end
      if (roll < 85) begin
         return $urandom_range(1, 3);
      end
      if (roll < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 40);
   endfunction

   function automatic request_row random_word();
      request_row w;
      int         roll;
      w.index = 4'($urandom_range(0, 15));
      w.value = $urandom;
      w.angle = 16'($urandom);
      w.axis  = ($urandom_range(0, 9) == 0) ? AXIS_NONE : 2'($urandom_range(0, 2));
      w.pin   = PIN_NONE;
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
         w.cmd = CMD_NEW;
      end else if (roll < 50) begin
         w.cmd = CMD_APPLY;
      end else if (roll < 75) begin
         w.cmd = CMD_WRITE;
      end else begin
         w.cmd = CMD_READ;
      end
      // favor the quadrant boundaries now and then
      if ($urandom_range(0, 4) == 0) begin
         case ($urandom_range(0, 5))
            0:       w.angle = 16'h0000;
            1:       w.angle = 16'h4000;
            2:       w.angle = 16'h8000;
            3:       w.angle = 16'hC000;
            4:       w.angle = 16'hFFFF;
            default: w.angle = 16'h7FFF;
         endcase
      end
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
         case ($urandom_range(0, 3))
            0:       w.value = 32'h7FFF_FFFF;
            1:       w.value = 32'h8000_0000;
            2:       w.value = 32'h0;
            default: w.value = 32'hFFFF_FFFF;
         endcase
      end else if (roll < 55) begin
         // keep a share of elements within +-2.0 so rotations stay clear of the clamp
         w.value = 32'($urandom_range(0, 262143)) - 32'd131072;
      end
      return w;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
      mismatches++;
   endtask

   // Offer one word, hold it until the unit takes it, then advance the prediction
   task automatic offer_word(input request_row w);
      int gap;
      gap = next_gap(tx_calm);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push          <= 1'b1;
      req_cmd           <= w.cmd;
      req_axis          <= w.axis;
      req_angle         <= w.angle;
      req_element_index <= w.index;
      req_element_value <= w.value;
      do @(posedge clock); while (req_full);
      advance_matrix_model(w);
   endtask

   // Sender: reset, directed table, random words, drain, verdict
   initial begin
      reset             <= 1'b1;
      req_push          <= 1'b0;
      req_cmd           <= CMD_NEW;
      req_axis          <= AXIS_X;
      req_angle         <= 16'sh0;
      req_element_index <= 4'd0;
      req_element_value <= 32'sh0;
      mismatches = 0;
      tx_calm    = 0;
      fill_sine_tab();
      reset_matrix_model();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      for (int k = 0; k < DIRECTED_ROWS; k++) begin
         offer_word(DIRECTED[k]);
      end
      for (int k = 0; k < RANDOM_WORDS; k++) begin
         offer_word(random_word());
      end
      req_push <= 1'b0;
      while (expected_elements.size() != 0) @(posedge clock);
      // catch any stray element arriving after the last expected one
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

   // Receiver: random pop stalls, plus one long hold-off to back the unit up
   initial begin
      int gap;
      int popped;
      bit held;
      rsp_pop <= 1'b0;
      rx_calm = 0;
      popped  = 0;
      held    = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (!held && popped >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_pop <= 1'b0;
            for (int n = 0; n < HOLD_CYCLES; n++) begin
               @(posedge clock);
            end
         end
         gap = next_gap(rx_calm);
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         popped++;
      end
   end

   // Compare each accepted element with the oldest expectation
   always @(posedge clock) begin
      matrix_element want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_elements.size() == 0) begin
            report_mismatch("unexpected element", {28'h0, rsp_out_index}, 32'h0);
         end else begin
            want = expected_elements.pop_front();
            if (rsp_out_index !== want.index) begin
               report_mismatch("out_index", {28'h0, rsp_out_index}, {28'h0, want.index});
            end
            if (rsp_out_value !== want.value) begin
               report_mismatch($sformatf("out_value[%0d]", want.index), rsp_out_value,
                               want.value);
            end
            if (rsp_last !== want.last) begin
               report_mismatch($sformatf("last[%0d]", want.index), {31'h0, rsp_last},
                               {31'h0, want.last});
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   initial cycle_count = 0;

endmodule

// File: files.f
sv/mar_pkg.sv
sv/mar_queue.sv
sv/mar_front.sv
sv/mar_back.sv
sv/matrix_axis_rotation_unit.sv
tb/sv/testbench.sv
